[rtl/ritoa_pkg.sv]
// Shared constants, types and helpers for the radix integer-to-ASCII unit.
`timescale 1ns / 1ps
package ritoa_pkg;

    localparam int VALUE_W    = 64;
    localparam int RADIX_W    = 6;
    localparam int DIGIT_W    = 6;
    localparam int CHAR_W     = 7;

    localparam int MAX_DIGITS  = 64;
    localparam int STORE_DEPTH = 64;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = $clog2(MAX_DIGITS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_BITS_PER_STEP = 8;
    localparam int DIV_STEPS         = VALUE_W / DIV_BITS_PER_STEP;
    localparam int DIV_STEP_W        = $clog2(DIV_STEPS);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

    localparam logic [DIGIT_W-1:0] DIGIT_NINE   = DIGIT_W'(9);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO    = CHAR_W'(48);
    // 'A' minus ten, so digit ten lands on 'A'
    localparam logic [CHAR_W-1:0]  CHAR_LETTERS = CHAR_W'(55);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [RADIX_W-1:0] radix;
    } t_job;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [RADIX_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quot;
        logic [DIGIT_W-1:0] rem;
    } t_div_rsp;

    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = CHAR_W'(d);
        if (d > DIGIT_NINE) begin
            return d_ext + CHAR_LETTERS;
        end
        return d_ext + CHAR_ZERO;
    endfunction

endpackage

[rtl/radix_integer_to_ascii_unit.sv]
// Top level of the radix integer-to-ASCII unit.
`timescale 1ns / 1ps
// Converts a 64-bit unsigned value into ASCII digits in a chosen base.
// Input channel: push/full queue. A transaction carries i_value and i_radix;
// the base is clamped to 2..36. A two-entry job queue sits behind the input,
// so up to two numbers can wait while another is converted.
// Result channel: empty/pop queue. Each transaction is one character on
// o_digit_char ('0'-'9', then 'A'-'Z'), most significant digit first; o_last
// marks the final character of a number. Zero yields the single character '0'.
// Timing: digits come from an iterative divider that retires eight quotient
// bits per cycle. Readout then streams one character per cycle while the
// receiver keeps popping, from the digit store through a two-entry output
// queue. Base 2 with a full 64 digits is the longest conversion.
// Only one number is converted at a time; the next begins once the current
// one's readout has been issued.
// Reset: synchronous, active low; clears both queues and the sequencer.
// When the receiver stalls, characters hold at the head of the output queue;
// readout pauses, and once the job queue fills, full rises and input stops.
module radix_integer_to_ascii_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [ritoa_pkg::VALUE_W-1:0] i_value,
    input  logic [ritoa_pkg::RADIX_W-1:0] i_radix,
    output logic                          empty,
    input  logic                          pop,
    output logic [ritoa_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                          o_last
);
    import ritoa_pkg::*;

    t_job     job;
    logic     job_valid;
    logic     job_pop;
    t_div_req div_req;
    t_div_rsp div_rsp;

    // accept, clamp the base and buffer jobs
    ritoa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .o_job       (job),
        .o_job_valid (job_valid),
        .i_job_pop   (job_pop)
    );

    // iterative divider: one digit per invocation
    ritoa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequence division, store digits, stream them out in reverse
    ritoa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (job),
        .i_job_valid  (job_valid),
        .o_job_pop    (job_pop),
        .o_div_req    (div_req),
        .i_div_rsp    (div_rsp),
        .empty        (empty),
        .pop          (pop),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule

[rtl/ritoa_front.sv]
// Front end: input acceptance, radix saturation and the job queue.
`timescale 1ns / 1ps
module ritoa_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [ritoa_pkg::VALUE_W-1:0] i_value,
    input  logic [ritoa_pkg::RADIX_W-1:0] i_radix,
    output ritoa_pkg::t_job         o_job,
    output logic                    o_job_valid,
    input  logic                    i_job_pop
);
    import ritoa_pkg::*;

    t_job                r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp;
    logic [QUEUE_AW-1:0] r_rp;
    logic [QUEUE_CW-1:0] r_cnt;

    logic         push_fire;
    logic         pop_fire;
    t_job         job_in;
    logic [RADIX_W-1:0] radix_sat;

    // clamp the base into the supported range
    always_comb begin
        if (i_radix < RADIX_MIN) begin
            radix_sat = RADIX_MIN;
        end else if (i_radix > RADIX_MAX) begin
            radix_sat = RADIX_MAX;
        end else begin
            radix_sat = i_radix;
        end
        job_in.value = i_value;
        job_in.radix = radix_sat;
    end

    assign full        = (r_cnt == QUEUE_CW'(QUEUE_DEPTH));
    assign push_fire   = push && !full;
    assign o_job_valid = (r_cnt != '0);
    assign pop_fire    = i_job_pop && o_job_valid;
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_q[r_wp] <= job_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_fire) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop_fire) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push_fire, pop_fire})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[rtl/ritoa_div.sv]
// Iterative divider: 64-bit dividend by a small base, eight quotient bits a cycle.
`timescale 1ns / 1ps
module ritoa_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ritoa_pkg::t_div_req i_req,
    output ritoa_pkg::t_div_rsp o_rsp
);
    import ritoa_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [VALUE_W-1:0]    r_quot;
    logic [DIGIT_W-1:0]    r_rem;
    logic [RADIX_W-1:0]    r_div;

    logic [VALUE_W-1:0]    n_quot;
    logic [DIGIT_W-1:0]    n_rem;

    // restoring division over one chunk of dividend bits
    always_comb begin
        logic [DIGIT_W:0] rem_ext;
        logic             ge;
        n_quot = r_quot;
        n_rem  = r_rem;
        for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
            rem_ext = {n_rem, n_quot[VALUE_W-1]};
            ge      = (rem_ext >= {1'b0, r_div});
            if (ge) begin
                rem_ext = rem_ext - {1'b0, r_div};
            end
            n_rem  = rem_ext[DIGIT_W-1:0];
            n_quot = {n_quot[VALUE_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= !i_req.start && r_busy
                   && (r_step == DIV_STEP_W'(DIV_STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == DIV_STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule

[rtl/ritoa_back.sv]
// Back end: digit generation sequencer, digit store and character output queue.
`timescale 1ns / 1ps
module ritoa_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ritoa_pkg::t_job     i_job,
    input  logic                i_job_valid,
    output logic                o_job_pop,
    output ritoa_pkg::t_div_req o_div_req,
    input  ritoa_pkg::t_div_rsp i_div_rsp,
    output logic                empty,
    input  logic                pop,
    output logic [ritoa_pkg::CHAR_W-1:0] o_digit_char,
    output logic                o_last
);
    import ritoa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 2);

    t_state              r_state;
    t_div_req            r_div_req;
    logic [COUNT_W-1:0]  r_count;
    logic [STORE_AW-1:0] r_rd_idx;

    logic [DIGIT_W-1:0]  r_store [STORE_DEPTH];
    logic [DIGIT_W-1:0]  r_rd_digit;
    logic                r_rd_last;
    logic                r_inflight;

    logic [CHAR_W-1:0]   r_oq_char [OUTQ_DEPTH];
    logic                r_oq_last [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]  r_oq_wp;
    logic [OUTQ_AW-1:0]  r_oq_rp;
    logic [OUTQ_CW-1:0]  r_oq_cnt;

    logic               job_take;
    logic               digit_we;
    logic               more;
    logic [COUNT_W-1:0] count_inc;
    logic               pop_fire;
    logic [OUTQ_CW-1:0] occupancy;
    logic               rd_en;

    assign job_take  = (r_state == S_IDLE) && i_job_valid;
    assign o_job_pop = job_take;
    assign digit_we  = (r_state == S_DIV) && i_div_rsp.done;
    assign count_inc = r_count + 1'b1;
    assign more      = (i_div_rsp.quot != '0) && (count_inc < COUNT_W'(MAX_DIGITS));
    assign pop_fire  = pop && (r_oq_cnt != '0);
    // entries held plus the one still coming out of the store
    assign occupancy = r_oq_cnt + OUTQ_CW'(r_inflight);
    assign rd_en     = (r_state == S_EMIT)
                    && ((occupancy < OUTQ_CW'(OUTQ_DEPTH))
                     || ((occupancy == OUTQ_CW'(OUTQ_DEPTH)) && pop_fire));
    assign o_div_req = r_div_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_req <= '0;
            r_count   <= '0;
            r_rd_idx  <= '0;
        end else begin
            // kick the divider for a new job or for the next digit
            r_div_req.start <= job_take || (digit_we && more);
            unique case (r_state)
                S_IDLE: begin
                    if (job_take) begin
                        r_div_req.dividend <= i_job.value;
                        r_div_req.divisor  <= i_job.radix;
                        r_count            <= '0;
                        r_state            <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_count <= count_inc;
                        if (more) begin
                            r_div_req.dividend <= i_div_rsp.quot;
                        end else begin
                            // most significant digit sits at the slot just written
                            r_rd_idx <= r_count[STORE_AW-1:0];
                            r_state  <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (rd_en) begin
                        r_rd_idx <= r_rd_idx - 1'b1;
                        if (r_rd_idx == '0) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // digit store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (digit_we) begin
            r_store[r_count[STORE_AW-1:0]] <= i_div_rsp.rem;
        end
        if (rd_en) begin
            r_rd_digit <= r_store[r_rd_idx];
            r_rd_last  <= (r_rd_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_inflight) begin
            r_oq_char[r_oq_wp] <= digit_to_char(r_rd_digit);
            r_oq_last[r_oq_wp] <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 1'b0;
            r_oq_wp    <= '0;
            r_oq_rp    <= '0;
            r_oq_cnt   <= '0;
        end else begin
            r_inflight <= rd_en;
            if (r_inflight) begin
                r_oq_wp <= r_oq_wp + 1'b1;
            end
            if (pop_fire) begin
                r_oq_rp <= r_oq_rp + 1'b1;
            end
            case ({r_inflight, pop_fire})
                2'b10:   r_oq_cnt <= r_oq_cnt + 1'b1;
                2'b01:   r_oq_cnt <= r_oq_cnt - 1'b1;
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

    assign empty        = (r_oq_cnt == '0);
    assign o_digit_char = r_oq_char[r_oq_rp];
    assign o_last       = r_oq_last[r_oq_rp];

`ifndef SYNTHESIS
    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight |-> ((r_oq_cnt < OUTQ_CW'(OUTQ_DEPTH)) || pop_fire))
        else $error("character queue written while full");

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= OUTQ_CW'(OUTQ_DEPTH))
        else $error("character queue count out of range");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside digit generation");

    a_last_ends_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && (r_rd_idx == '0)) |=> (r_state == S_IDLE) && r_inflight && r_rd_last)
        else $error("final character read did not end the readout");
`endif

endmodule
